FILE: hdl/tdr_pkg.sv
// shared types and constants of the task dependency release tracker
package tdr_pkg;

   localparam int DEF_MAX_TASKS      = 256;
   localparam int DEF_MAX_DEPENDENTS = 16;

   localparam int TASK_W  = 8;
   localparam int COUNT_W = 9;
   // list length field, holds up to 127 dependents
   localparam int LEN_W   = 7;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      KIND_MARK  = 2'd0,
      KIND_EDGE  = 2'd1,
      KIND_QUERY = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_RANGE    = 2'd1,
      STAT_INACTIVE = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] count;
      logic [LEN_W-1:0]   len;
   } task_row_type;

   typedef struct packed {
      logic [TASK_W-1:0] task_id;
      logic              ready;
      status_type        status;
      logic              last;
   } result_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_RD_T,
      S_HAVE_T,
      S_RD_O,
      S_HAVE_O,
      S_EDGE_WT,
      S_DEP_RD,
      S_DEP_CNT,
      S_DEP_UPD,
      S_EMIT
   } seq_state_type;

endpackage

FILE: hdl/tdr_task_mem.sv
// per-task row memory: active bit, waiting count, dependent list length
module tdr_task_mem #(
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output tdr_pkg::task_row_type      rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  tdr_pkg::task_row_type      wr_data
);
   import tdr_pkg::*;

   task_row_type mem_ff [DEPTH];
   task_row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tdr_dep_mem.sv
// dependent list memory, one row of list slots per task
module tdr_dep_mem #(
   parameter int DEPTH = 4096
) (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [tdr_pkg::TASK_W-1:0]       rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [tdr_pkg::TASK_W-1:0]       wr_data
);
   import tdr_pkg::*;

   logic [TASK_W-1:0] mem_ff [DEPTH];
   logic [TASK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tdr_seq.sv
// sequencer: decodes items, runs read-modify-write on both memories, holds the result register
module tdr_seq #(
   parameter int MAX_TASKS      = tdr_pkg::DEF_MAX_TASKS,
   parameter int MAX_DEPENDENTS = tdr_pkg::DEF_MAX_DEPENDENTS
) (
   input  logic                                              clock,
   input  logic                                              reset,
   // item side
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  tdr_pkg::kind_type                                 in_kind,
   input  logic [tdr_pkg::TASK_W-1:0]                        in_tid,
   input  logic [tdr_pkg::TASK_W-1:0]                        in_oid,
   input  logic                                              in_active,
   // result side
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output tdr_pkg::result_type                               out_res,
   // task memory
   output logic                                              trow_rd_en,
   output logic [$clog2(MAX_TASKS)-1:0]                      trow_rd_addr,
   input  tdr_pkg::task_row_type                             trow_rd_data,
   output logic                                              trow_wr_en,
   output logic [$clog2(MAX_TASKS)-1:0]                      trow_wr_addr,
   output tdr_pkg::task_row_type                             trow_wr_data,
   // dependent list memory
   output logic                                              dep_rd_en,
   output logic [$clog2(MAX_TASKS*MAX_DEPENDENTS)-1:0]       dep_rd_addr,
   input  logic [tdr_pkg::TASK_W-1:0]                        dep_rd_data,
   output logic                                              dep_wr_en,
   output logic [$clog2(MAX_TASKS*MAX_DEPENDENTS)-1:0]       dep_wr_addr,
   output logic [tdr_pkg::TASK_W-1:0]                        dep_wr_data
);
   import tdr_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TASKS);
   localparam int DEP_AW = $clog2(MAX_TASKS * MAX_DEPENDENTS);
   localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_TASKS - 1);

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

   seq_state_type     state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [TASK_W-1:0] tid_ff, tid_in;
   logic [TASK_W-1:0] oid_ff, oid_in;
   logic              act_ff, act_in;
   task_row_type      row_t_ff, row_t_in;
   logic [LEN_W-1:0]  ptr_ff, ptr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [TASK_W-1:0] d_ff, d_in;
   logic              d_bad_ff, d_bad_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [TASK_W-1:0] pend_tid_ff, pend_tid_in;
   result_type        res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_res_ff, out_res_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;

   logic              push;
   result_type        push_res;
   logic              out_free;
   logic              req_bad;
   logic [IDX_W-1:0]  t_idx, o_idx;
   logic              same_task;
   logic              dep_hit, dep_ready, dep_stall, dep_more;
   logic              row_full;

   assign out_free  = !out_valid_ff || out_ready;
   assign t_idx     = IDX_W'(tid_ff);
   assign o_idx     = IDX_W'(oid_ff);
   assign same_task = (tid_ff == oid_ff);

   // the task id, or for an edge item the other id, of the incoming item out of range
   assign req_bad = (32'(in_tid) >= 32'(MAX_TASKS)) ||
                    ((in_kind == KIND_EDGE) && (32'(in_oid) >= 32'(MAX_TASKS)));

   assign row_full = 32'(trow_rd_data.len) >= 32'(MAX_DEPENDENTS);

   // counting down one dependent
   assign dep_hit   = !d_bad_ff && (trow_rd_data.count != '0);
   assign dep_ready = dep_hit && (trow_rd_data.count == COUNT_W'(1));
   assign dep_stall = dep_ready && pend_valid_ff && !out_free;
   assign dep_more  = ptr_ff < len_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == LAST_ROW) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (in_valid) state_in = req_bad ? S_EMIT : S_RD_T;
         end
         S_RD_T: state_in = S_HAVE_T;
         S_HAVE_T: begin
            unique case (kind_ff)
               KIND_MARK, KIND_QUERY: state_in = S_EMIT;
               KIND_EDGE:             state_in = S_RD_O;
               KIND_DONE:             state_in = (trow_rd_data.len == '0) ? S_EMIT : S_DEP_RD;
               default:               state_in = S_EMIT;
            endcase
         end
         S_RD_O: state_in = S_HAVE_O;
         S_HAVE_O: begin
            if (!row_t_ff.active || !trow_rd_data.active || row_full || same_task) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_EDGE_WT;
            end
         end
         S_EDGE_WT: state_in = S_EMIT;
         S_DEP_RD:  state_in = S_DEP_CNT;
         S_DEP_CNT: state_in = S_DEP_UPD;
         S_DEP_UPD: begin
            if (!dep_stall) state_in = dep_more ? S_DEP_CNT : S_EMIT;
         end
         S_EMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      in_ready      = 1'b0;
      trow_rd_en    = 1'b0;
      trow_rd_addr  = t_idx;
      trow_wr_en    = 1'b0;
      trow_wr_addr  = t_idx;
      trow_wr_data  = row_t_ff;
      dep_rd_en     = 1'b0;
      dep_rd_addr   = DEP_AW'(32'(t_idx) * MAX_DEPENDENTS + 32'(ptr_ff));
      dep_wr_en     = 1'b0;
      dep_wr_addr   = DEP_AW'(32'(o_idx) * MAX_DEPENDENTS + 32'(trow_rd_data.len));
      dep_wr_data   = tid_ff;
      push          = 1'b0;
      push_res      = res_ff;
      kind_in       = kind_ff;
      tid_in        = tid_ff;
      oid_in        = oid_ff;
      act_in        = act_ff;
      row_t_in      = row_t_ff;
      ptr_in        = ptr_ff;
      len_in        = len_ff;
      d_in          = d_ff;
      d_bad_in      = d_bad_ff;
      pend_valid_in = pend_valid_ff;
      pend_tid_in   = pend_tid_ff;
      res_in        = res_ff;
      clr_in        = clr_ff;

      unique case (state_ff)
         S_CLEAR: begin
            trow_wr_en   = 1'b1;
            trow_wr_addr = clr_ff;
            trow_wr_data = '0;
            clr_in       = clr_ff + IDX_W'(1);
         end
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               kind_in       = in_kind;
               tid_in        = in_tid;
               oid_in        = in_oid;
               act_in        = in_active;
               ptr_in        = '0;
               pend_valid_in = 1'b0;
               res_in        = '{task_id: in_tid, ready: 1'b0, status: STAT_RANGE, last: 1'b1};
            end
         end
         S_RD_T: begin
            trow_rd_en = 1'b1;
         end
         S_HAVE_T: begin
            row_t_in = trow_rd_data;
            len_in   = trow_rd_data.len;
            res_in   = '{task_id: tid_ff, ready: 1'b0, status: STAT_OK, last: 1'b1};
            unique case (kind_ff)
               KIND_MARK: begin
                  trow_wr_en   = 1'b1;
                  trow_wr_data = '{active: act_ff, count: trow_rd_data.count,
                                   len: trow_rd_data.len};
                  res_in.ready = act_ff && (trow_rd_data.count == '0);
               end
               KIND_QUERY: begin
                  res_in.ready = trow_rd_data.active && (trow_rd_data.count == '0);
               end
               default: begin
               end
            endcase
         end
         S_RD_O: begin
            trow_rd_en   = 1'b1;
            trow_rd_addr = o_idx;
         end
         S_HAVE_O: begin
            res_in = '{task_id: tid_ff, ready: 1'b0, status: STAT_OK, last: 1'b1};
            if (!row_t_ff.active || !trow_rd_data.active) begin
               res_in.status = STAT_INACTIVE;
            end else if (row_full) begin
               res_in.status = STAT_FULL;
            end else begin
               // append to the list of the task depended on; a self edge also counts here
               dep_wr_en    = 1'b1;
               trow_wr_en   = 1'b1;
               trow_wr_addr = o_idx;
               trow_wr_data = '{active: trow_rd_data.active,
                                count:  same_task ? sat_inc(trow_rd_data.count)
                                                  : trow_rd_data.count,
                                len:    trow_rd_data.len + LEN_W'(1)};
            end
         end
         S_EDGE_WT: begin
            trow_wr_en   = 1'b1;
            trow_wr_data = '{active: row_t_ff.active, count: sat_inc(row_t_ff.count),
                             len: row_t_ff.len};
         end
         S_DEP_RD: begin
            dep_rd_en = 1'b1;
         end
         S_DEP_CNT: begin
            // fetch the dependent's row and prefetch the next list slot
            d_in         = dep_rd_data;
            d_bad_in     = 32'(dep_rd_data) >= 32'(MAX_TASKS);
            trow_rd_en   = 32'(dep_rd_data) < 32'(MAX_TASKS);
            trow_rd_addr = IDX_W'(dep_rd_data);
            dep_rd_en    = (ptr_ff + LEN_W'(1)) < len_ff;
            dep_rd_addr  = DEP_AW'(32'(t_idx) * MAX_DEPENDENTS + 32'(ptr_ff) + 32'd1);
            ptr_in       = ptr_ff + LEN_W'(1);
         end
         S_DEP_UPD: begin
            if (!dep_stall) begin
               trow_wr_en   = dep_hit;
               trow_wr_addr = IDX_W'(d_ff);
               trow_wr_data = '{active: trow_rd_data.active,
                                count:  trow_rd_data.count - COUNT_W'(1),
                                len:    trow_rd_data.len};
               if (dep_ready) begin
                  // the held ready task is not the final one any more
                  push          = pend_valid_ff;
                  push_res      = '{task_id: pend_tid_ff, ready: 1'b1, status: STAT_OK,
                                    last: 1'b0};
                  pend_valid_in = 1'b1;
                  pend_tid_in   = d_ff;
               end
               if (!dep_more) begin
                  if (dep_ready) begin
                     res_in = '{task_id: d_ff, ready: 1'b1, status: STAT_OK, last: 1'b1};
                  end else if (pend_valid_ff) begin
                     res_in = '{task_id: pend_tid_ff, ready: 1'b1, status: STAT_OK,
                                last: 1'b1};
                  end else begin
                     res_in = '{task_id: tid_ff, ready: 1'b0, status: STAT_OK, last: 1'b1};
                  end
               end
            end
         end
         S_EMIT: begin
            push = out_free;
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      out_res_in = out_res_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_res_in   = push_res;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      kind_ff     <= kind_in;
      tid_ff      <= tid_in;
      oid_ff      <= oid_in;
      act_ff      <= act_in;
      row_t_ff    <= row_t_in;
      ptr_ff      <= ptr_in;
      len_ff      <= len_in;
      d_ff        <= d_in;
      d_bad_ff    <= d_bad_in;
      pend_tid_ff <= pend_tid_in;
      res_ff      <= res_in;
      out_res_ff  <= out_res_in;
   end

   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

endmodule

FILE: hdl/task_dependency_release_tracker_top.sv
// top level of the task dependency release tracker
// Task scoreboard. Each task has a row in a task memory (active bit, 9-bit
// saturating count of dependencies still pending, dependent list length) and
// a row of MAX_DEPENDENTS slots in a dependent list memory. One item is worked
// on at a time. An edge item reads its two ends one after the other on the
// single read port of the task memory, and a completion walks the list, where
// each entry is a read of the dependent's row followed by the write-back of its
// decremented count. A result register sits on the output, so a new item is
// taken while the last result waits; a blocked result port holds an item in its
// final cycle until that register frees, and stalls a completion walk when a
// second released task needs to go out. After reset a clearing pass zeroes every
// row of the task memory, one row a cycle, during which no item is taken.
module task_dependency_release_tracker_top #(
   parameter int MAX_TASKS      = tdr_pkg::DEF_MAX_TASKS,
   parameter int MAX_DEPENDENTS = tdr_pkg::DEF_MAX_DEPENDENTS
) (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // task_id[7:0], other_task_id[15:8], active[16], zero pad
   input  logic [1:0]  req_tuser,   // kind[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_task[7:0], ready_res[8], status[10:9], zero pad
   output logic        rsp_tlast    // final result of the item
);
   import tdr_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TASKS);
   localparam int DEP_N  = MAX_TASKS * MAX_DEPENDENTS;
   localparam int DEP_AW = $clog2(DEP_N);

   // task memory port
   logic              trow_rd_en;
   logic [IDX_W-1:0]  trow_rd_addr;
   task_row_type      trow_rd_data;
   logic              trow_wr_en;
   logic [IDX_W-1:0]  trow_wr_addr;
   task_row_type      trow_wr_data;

   // dependent list memory port
   logic              dep_rd_en;
   logic [DEP_AW-1:0] dep_rd_addr;
   logic [TASK_W-1:0] dep_rd_data;
   logic              dep_wr_en;
   logic [DEP_AW-1:0] dep_wr_addr;
   logic [TASK_W-1:0] dep_wr_data;

   result_type        rsp_res;

   tdr_task_mem #(
      .DEPTH (MAX_TASKS)
   ) u_task_mem (
      .clock   (clock),
      .rd_en   (trow_rd_en),
      .rd_addr (trow_rd_addr),
      .rd_data (trow_rd_data),
      .wr_en   (trow_wr_en),
      .wr_addr (trow_wr_addr),
      .wr_data (trow_wr_data)
   );

   tdr_dep_mem #(
      .DEPTH (DEP_N)
   ) u_dep_mem (
      .clock   (clock),
      .rd_en   (dep_rd_en),
      .rd_addr (dep_rd_addr),
      .rd_data (dep_rd_data),
      .wr_en   (dep_wr_en),
      .wr_addr (dep_wr_addr),
      .wr_data (dep_wr_data)
   );

   // sequencer owns the item decode, both memory ports and the result register
   tdr_seq #(
      .MAX_TASKS      (MAX_TASKS),
      .MAX_DEPENDENTS (MAX_DEPENDENTS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_kind      (kind_type'(req_tuser)),
      .in_tid       (req_tdata[7:0]),
      .in_oid       (req_tdata[15:8]),
      .in_active    (req_tdata[16]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_res      (rsp_res),
      .trow_rd_en   (trow_rd_en),
      .trow_rd_addr (trow_rd_addr),
      .trow_rd_data (trow_rd_data),
      .trow_wr_en   (trow_wr_en),
      .trow_wr_addr (trow_wr_addr),
      .trow_wr_data (trow_wr_data),
      .dep_rd_en    (dep_rd_en),
      .dep_rd_addr  (dep_rd_addr),
      .dep_rd_data  (dep_rd_data),
      .dep_wr_en    (dep_wr_en),
      .dep_wr_addr  (dep_wr_addr),
      .dep_wr_data  (dep_wr_data)
   );

   // pack the result item
   assign rsp_tdata = {5'b0, rsp_res.status, rsp_res.ready, rsp_res.task_id};
   assign rsp_tlast = rsp_res.last;

endmodule
